FILE: sv/cke_pkg.sv
// shared types and constants for the color key run extractor
package cke_pkg;

  localparam int BYTE_W     = 8;
  localparam int NUM_BYTES  = 3;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hff;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FRAME_RST  = 4096;
  localparam logic [BYTE_W-1:0] KEY_RST = 8'd0;
  localparam logic [BYTE_W-1:0] TOL_RST = 8'd16;

  localparam int RUN_LEFT_W  = 12;
  localparam int RUN_RIGHT_W = 13;
  localparam int RUN_ROW_W   = 12;
  localparam int BOX_W       = 13;

  localparam int IN_TDATA_W   = 24;
  localparam int OUT_FIELDS_W = RUN_LEFT_W + RUN_RIGHT_W + RUN_ROW_W + 4 * BOX_W;
  localparam int OUT_TDATA_W  = 96;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [NUM_BYTES-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_TOL0   = 3'd3,
    CFG_TOL1   = 3'd4,
    CFG_TOL2   = 3'd5,
    CFG_WIDTH  = 3'd6,
    CFG_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                   run_valid;
    logic [RUN_LEFT_W-1:0]  run_left;
    logic [RUN_RIGHT_W-1:0] run_right;
    logic [RUN_ROW_W-1:0]   run_row;
    logic                   batch_end;
    logic [BOX_W-1:0]       box_left;
    logic [BOX_W-1:0]       box_top;
    logic [BOX_W-1:0]       box_right;
    logic [BOX_W-1:0]       box_bottom;
  } out_item_t;

endpackage

FILE: sv/cke_key_match.sv
// color key window test of one pixel, opaque when any byte is outside its window
module cke_key_match import cke_pkg::*; (
  input  pixel_t pix,
  input  pixel_t key,
  input  pixel_t tol,
  output logic   opaque
);

  logic [NUM_BYTES-1:0] hit;

  always_comb begin
    logic [BYTE_W:0] sum;
    byte_t           hi;
    for (int k = 0; k < NUM_BYTES; k++) begin
      sum    = {1'b0, key[k]} + {1'b0, tol[k]};
      hi     = sum[BYTE_W] ? BYTE_MAX : sum[BYTE_W-1:0];
      hit[k] = (pix[k] >= key[k]) && (pix[k] <= hi);
    end
  end

  assign opaque = !(&hit);

endmodule

FILE: sv/color_key_run_extractor_top.sv
// color key run extractor top level: pixel stage, run and batch tracking, result queue
//
// Pixels enter in raster order, one per clock, and every pixel is taken at full rate as
// long as results drain. An accepted pixel is held in the input register, where the color
// key test and the run and batch update are done, and its result (if any) is registered
// into the result queue before it reaches the output. A result item leaves only when an
// opaque run finishes or a batch closes (BATCH_RECTS runs, or the last pixel of a frame);
// a two-entry queue takes one more result while downstream stalls. Frame sizes are
// clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT when written; configuration is taken at any
// time, one write per cycle, and must be written only while no pixel is in flight.
module color_key_run_extractor_top import cke_pkg::*; #(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int BATCH_RECTS = 2000
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pix_byte0, pix_byte1, pix_byte2
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // run_left, run_right, run_row, box_left, box_top, box_right, box_bottom, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // run_valid
  output logic                   out_tuser,
  // batch_end
  output logic                   out_tlast
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW  = $clog2(MAX_WIDTH + 1);
  localparam int YW  = $clog2(MAX_HEIGHT + 1);
  localparam int BCW = $clog2(BATCH_RECTS + 1);
  localparam int WLAST_RST = ((FRAME_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_RST) - 1;
  localparam int HLAST_RST = ((FRAME_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_RST) - 1;

  // configuration
  pixel_t        key_r, tol_r;
  logic [CW-1:0] wlast_r, wlast_wr;
  logic [RW-1:0] hlast_r, hlast_wr;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) begin
      wlast_wr = '0;
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      wlast_wr = CW'(MAX_WIDTH - 1);
    end else begin
      wlast_wr = CW'(cfg_data - CFG_DATA_W'(1));
    end
    if (cfg_data == '0) begin
      hlast_wr = '0;
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      hlast_wr = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast_wr = RW'(cfg_data - CFG_DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= {NUM_BYTES{KEY_RST}};
      tol_r   <= {NUM_BYTES{TOL_RST}};
      wlast_r <= CW'(WLAST_RST);
      hlast_r <= RW'(HLAST_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_KEY0:   key_r[0] <= cfg_data[BYTE_W-1:0];
        CFG_KEY1:   key_r[1] <= cfg_data[BYTE_W-1:0];
        CFG_KEY2:   key_r[2] <= cfg_data[BYTE_W-1:0];
        CFG_TOL0:   tol_r[0] <= cfg_data[BYTE_W-1:0];
        CFG_TOL1:   tol_r[1] <= cfg_data[BYTE_W-1:0];
        CFG_TOL2:   tol_r[2] <= cfg_data[BYTE_W-1:0];
        CFG_WIDTH:  wlast_r  <= wlast_wr;
        CFG_HEIGHT: hlast_r  <= hlast_wr;
        default: ;
      endcase
    end
  end

  // input register
  logic   p_valid_r;
  pixel_t p_pix_r;
  logic   p_adv;
  logic   opaque;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      p_valid_r <= 1'b1;
    end else if (p_adv) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      p_pix_r <= pixel_t'(in_tdata);
    end
  end

  cke_key_match u_match (
    .pix    (p_pix_r),
    .key    (key_r),
    .tol    (tol_r),
    .opaque (opaque)
  );

  // run and batch state
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           run_open_r, run_open_nxt;
  logic [CW-1:0]  run_start_r, run_start_nxt;
  logic [BCW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0]  bl_r, bl_nxt, br_r, br_nxt;
  logic [YW-1:0]  bt_r, bt_nxt, bb_r, bb_nxt;

  logic          row_end, frame_end, have_run, closing;
  logic [CW-1:0] start;
  logic [XW-1:0] r_right;
  logic [YW-1:0] r_row_ext, r_row_inc;
  logic [BCW-1:0] cnt_inc;
  logic [XW-1:0] ubl, ubr;
  logic [YW-1:0] ubt, ubb;
  out_item_t     res;

  always_comb begin
    row_end   = col_r >= wlast_r;
    frame_end = row_end && (row_r >= hlast_r);
    start     = run_open_r ? run_start_r : col_r;
    have_run  = (run_open_r || opaque) && (!opaque || row_end);
    r_right   = opaque ? XW'(col_r) + XW'(1) : XW'(col_r);
    r_row_ext = YW'(row_r);
    r_row_inc = r_row_ext + YW'(1);
    cnt_inc   = cnt_r + BCW'(have_run);
    closing   = (have_run && (cnt_inc >= BCW'(BATCH_RECTS))) || frame_end;

    ubl = bl_r;
    ubt = bt_r;
    ubr = br_r;
    ubb = bb_r;
    if (have_run) begin
      if (XW'(start) < bl_r) ubl = XW'(start);
      if (r_row_ext < bt_r)  ubt = r_row_ext;
      if (r_right > br_r)    ubr = r_right;
      if (r_row_inc > bb_r)  ubb = r_row_inc;
    end

    res           = '0;
    res.run_valid = have_run;
    res.batch_end = closing;
    if (have_run) begin
      res.run_left  = RUN_LEFT_W'(start);
      res.run_right = RUN_RIGHT_W'(r_right);
      res.run_row   = RUN_ROW_W'(row_r);
    end
    if (closing) begin
      res.box_left   = BOX_W'(ubl);
      res.box_top    = BOX_W'(ubt);
      res.box_right  = BOX_W'(ubr);
      res.box_bottom = BOX_W'(ubb);
    end

    if (closing) begin
      cnt_nxt = '0;
      bl_nxt  = XW'(MAX_WIDTH);
      bt_nxt  = YW'(MAX_HEIGHT);
      br_nxt  = '0;
      bb_nxt  = '0;
    end else begin
      cnt_nxt = cnt_inc;
      bl_nxt  = ubl;
      bt_nxt  = ubt;
      br_nxt  = ubr;
      bb_nxt  = ubb;
    end

    run_start_nxt = (opaque && !run_open_r) ? col_r : run_start_r;
    run_open_nxt  = (run_open_r || opaque) && !have_run && !row_end;
    col_nxt       = row_end ? '0 : col_r + CW'(1);
    if (frame_end) begin
      row_nxt = '0;
    end else if (row_end) begin
      row_nxt = row_r + RW'(1);
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      run_open_r  <= 1'b0;
      run_start_r <= '0;
      cnt_r       <= '0;
      bl_r        <= XW'(MAX_WIDTH);
      bt_r        <= YW'(MAX_HEIGHT);
      br_r        <= '0;
      bb_r        <= '0;
    end else if (p_adv) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      run_open_r  <= run_open_nxt;
      run_start_r <= run_start_nxt;
      cnt_r       <= cnt_nxt;
      bl_r        <= bl_nxt;
      bt_r        <= bt_nxt;
      br_r        <= br_nxt;
      bb_r        <= bb_nxt;
    end
  end

  // two-entry result queue
  logic      head_valid_r, tail_valid_r;
  out_item_t head_r, tail_r;
  logic      push, pop;

  assign p_adv     = p_valid_r && (!(have_run || closing) || !tail_valid_r);
  assign push      = p_adv && (have_run || closing);
  assign pop       = head_valid_r && out_tready;
  assign in_tready = !p_valid_r || p_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      tail_valid_r <= 1'b0;
    end else if (!head_valid_r || pop) begin
      if (tail_valid_r) begin
        head_valid_r <= 1'b1;
        tail_valid_r <= push;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      tail_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid_r || pop) begin
      if (tail_valid_r) begin
        head_r <= tail_r;
        if (push) begin
          tail_r <= res;
        end
      end else if (push) begin
        head_r <= res;
      end
    end else if (push) begin
      tail_r <= res;
    end
  end

  assign out_tvalid = head_valid_r;
  assign out_tuser  = head_r.run_valid;
  assign out_tlast  = head_r.batch_end;
  assign out_tdata  = {OUT_PAD_W'(0), head_r.box_bottom, head_r.box_right, head_r.box_top,
                       head_r.box_left, head_r.run_row, head_r.run_right, head_r.run_left};

  // checks
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    tail_valid_r |-> head_valid_r)
    else $error("result queue tail valid without head");

  a_item_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (head_r.run_valid || head_r.batch_end))
    else $error("result item carries neither run nor batch close");

  a_batch_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < BCW'(BATCH_RECTS))
    else $error("batch count reached limit without close");

  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && head_r.run_valid) |-> (RUN_RIGHT_W'(head_r.run_left) < head_r.run_right))
    else $error("run right edge not beyond left edge");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && tail_valid_r) |-> (!head_valid_r || pop))
    else $error("result pushed into full queue");

endmodule

FILE: sim/tb.sv
// testbench for the color key run extractor: run and batch scoreboard, pixel and result drivers
`timescale 1ns / 1ps

module tb;
  import cke_pkg::*;

  localparam int MAX_W        = 4096;
  localparam int MAX_H        = 4096;
  localparam int BATCH_RUNS   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 40;

  localparam int RL_LO  = 0;
  localparam int RR_LO  = RL_LO + RUN_LEFT_W;
  localparam int ROW_LO = RR_LO + RUN_RIGHT_W;
  localparam int BL_LO  = ROW_LO + RUN_ROW_W;
  localparam int BT_LO  = BL_LO + BOX_W;
  localparam int BR_LO  = BT_LO + BOX_W;
  localparam int BB_LO  = BR_LO + BOX_W;

  typedef logic [CFG_DATA_W-1:0] dim_t;

  class run_scoreboard;
    pixel_t      key;
    pixel_t      tol;
    dim_t        width_reg;
    dim_t        height_reg;
    int unsigned col;
    int unsigned row;
    int unsigned run_start;
    int unsigned count;
    int unsigned bl;
    int unsigned bt;
    int unsigned br;
    int unsigned bb;
    bit          run_open;
    out_item_t   expected_runs[$];

    function new();
      key        = {NUM_BYTES{KEY_RST}};
      tol        = {NUM_BYTES{TOL_RST}};
      width_reg  = dim_t'(FRAME_RST);
      height_reg = dim_t'(FRAME_RST);
      col        = 0;
      row        = 0;
      run_start  = 0;
      run_open   = 1'b0;
      clear_box();
    endfunction

    function void clear_box();
      count = 0;
      bl    = MAX_W;
      bt    = MAX_H;
      br    = 0;
      bb    = 0;
    endfunction

    function int unsigned clamp(dim_t v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction

    function void write_reg(cfg_idx_t idx, dim_t data);
      case (idx)
        CFG_KEY0:   key[0] = data[BYTE_W-1:0];
        CFG_KEY1:   key[1] = data[BYTE_W-1:0];
        CFG_KEY2:   key[2] = data[BYTE_W-1:0];
        CFG_TOL0:   tol[0] = data[BYTE_W-1:0];
        CFG_TOL1:   tol[1] = data[BYTE_W-1:0];
        CFG_TOL2:   tol[2] = data[BYTE_W-1:0];
        CFG_WIDTH:  width_reg = data;
        CFG_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function void take_pixel(pixel_t p);
      int unsigned w;
      int unsigned h;
      int unsigned lim;
      int unsigned rl;
      int unsigned rr;
      int unsigned rrow;
      bit          opaque;
      bit          row_end;
      bit          frame_end;
      bit          have_run;
      bit          closing;
      out_item_t   item;
      w        = clamp(width_reg, MAX_W);
      h        = clamp(height_reg, MAX_H);
      opaque   = 1'b0;
      have_run = 1'b0;
      closing  = 1'b0;
      rl       = 0;
      rr       = 0;
      rrow     = 0;
      for (int k = 0; k < NUM_BYTES; k++) begin
        lim = int'(key[k]) + int'(tol[k]);
        if (lim > BYTE_MAX) lim = BYTE_MAX;
        if (p[k] < key[k] || p[k] > lim) opaque = 1'b1;
      end
      row_end   = col >= w - 1;
      frame_end = row_end && row >= h - 1;
      if (opaque && !run_open) begin
        run_open  = 1'b1;
        run_start = col;
      end
      if (run_open && (!opaque || row_end)) begin
        have_run = 1'b1;
        rl       = run_start;
        rr       = opaque ? col + 1 : col;
        rrow     = row;
        run_open = 1'b0;
        count++;
        if (rl < bl) bl = rl;
        if (rrow < bt) bt = rrow;
        if (rr > br) br = rr;
        if (rrow + 1 > bb) bb = rrow + 1;
        if (count >= BATCH_RUNS) closing = 1'b1;
      end
      if (frame_end) closing = 1'b1;
      if (have_run || closing) begin
        item           = '0;
        item.run_valid = have_run;
        item.run_left  = RUN_LEFT_W'(rl);
        item.run_right = RUN_RIGHT_W'(rr);
        item.run_row   = RUN_ROW_W'(rrow);
        if (closing) begin
          item.batch_end  = 1'b1;
          item.box_left   = BOX_W'(bl);
          item.box_top    = BOX_W'(bt);
          item.box_right  = BOX_W'(br);
          item.box_bottom = BOX_W'(bb);
          clear_box();
        end
        expected_runs.push_back(item);
      end
      if (row_end) begin
        col      = 0;
        run_open = 1'b0;
        row      = frame_end ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function string diff(string nm, int unsigned got, int unsigned want);
      if (got == want) return "";
      return $sformatf(" %s got %0d want %0d", nm, got, want);
    endfunction

    function string check_result(out_item_t got);
      out_item_t want;
      string     s;
      if (expected_runs.size() == 0) return "result item with none expected";
      want = expected_runs.pop_front();
      s = {diff("run_valid", got.run_valid, want.run_valid),
           diff("run_left", got.run_left, want.run_left),
           diff("run_right", got.run_right, want.run_right),
           diff("run_row", got.run_row, want.run_row),
           diff("batch_end", got.batch_end, want.batch_end),
           diff("box_left", got.box_left, want.box_left),
           diff("box_top", got.box_top, want.box_top),
           diff("box_right", got.box_right, want.box_right),
           diff("box_bottom", got.box_bottom, want.box_bottom)};
      if (s != "") s = {"result item:", s};
      return s;
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  dim_t                   cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  run_scoreboard sb;
  pixel_t        cur_key = {NUM_BYTES{KEY_RST}};
  pixel_t        cur_tol = {NUM_BYTES{TOL_RST}};
  bit            quiet = 1'b0;
  int            hold_req = 0;
  int            mismatch_count = 0;

  color_key_run_extractor_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .BATCH_RECTS(BATCH_RUNS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic pixel_t px(byte_t b0, byte_t b1, byte_t b2);
    return {b2, b1, b0};
  endfunction

  // random pixel inside the key window, or with one byte pushed outside it
  function automatic pixel_t make_pixel(bit opaque);
    pixel_t      p;
    int unsigned lo;
    int unsigned hi;
    int          k;
    for (k = 0; k < NUM_BYTES; k++) begin
      lo = cur_key[k];
      hi = lo + cur_tol[k];
      if (hi > BYTE_MAX) hi = BYTE_MAX;
      p[k] = opaque ? byte_t'($urandom_range(BYTE_MAX, 0)) : byte_t'($urandom_range(hi, lo));
    end
    if (opaque) begin
      k  = $urandom_range(NUM_BYTES - 1, 0);
      lo = cur_key[k];
      hi = lo + cur_tol[k];
      if (hi > BYTE_MAX) hi = BYTE_MAX;
      if (lo > 0 && (hi == BYTE_MAX || $urandom_range(1, 0) == 1)) begin
        p[k] = byte_t'($urandom_range(lo - 1, 0));
      end else if (hi < BYTE_MAX) begin
        p[k] = byte_t'($urandom_range(BYTE_MAX, hi + 1));
      end
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p);
    if (!quiet && $urandom_range(5, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_pixel(p);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input dim_t data);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input pixel_t key, input pixel_t tol, input dim_t w, input dim_t h);
    wait_idle();
    write_reg(CFG_KEY0, dim_t'(key[0]));
    write_reg(CFG_KEY1, dim_t'(key[1]));
    write_reg(CFG_KEY2, dim_t'(key[2]));
    write_reg(CFG_TOL0, dim_t'(tol[0]));
    write_reg(CFG_TOL1, dim_t'(tol[1]));
    write_reg(CFG_TOL2, dim_t'(tol[2]));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
    cur_key = key;
    cur_tol = tol;
  endtask

  // one-pixel frame so the next phase starts at row 0, column 0, empty batch
  task automatic align_frame();
    configure(cur_key, cur_tol, dim_t'(1), dim_t'(1));
    send_pixel(make_pixel($urandom_range(1, 0)));
  endtask

  task automatic random_setting();
    pixel_t key;
    pixel_t tol;
    dim_t   w;
    dim_t   h;
    for (int k = 0; k < NUM_BYTES; k++) begin
      case ($urandom_range(5, 0))
        0: key[k] = '0;
        1: key[k] = BYTE_MAX;
        default: key[k] = byte_t'($urandom_range(BYTE_MAX, 0));
      endcase
      case ($urandom_range(5, 0))
        0: tol[k] = '0;
        1: tol[k] = BYTE_MAX;
        default: tol[k] = byte_t'($urandom_range(40, 0));
      endcase
    end
    case ($urandom_range(9, 0))
      0: w = '0;
      1: w = dim_t'(1);
      2: w = dim_t'(MAX_W);
      3: w = '1;
      default: w = dim_t'($urandom_range(20, 2));
    endcase
    case ($urandom_range(9, 0))
      0: h = '0;
      1: h = dim_t'(1);
      2: h = '1;
      default: h = dim_t'($urandom_range(6, 1));
    endcase
    configure(key, tol, w, h);
  endtask

  task automatic run_random(input int n, input int flip_pct);
    bit opq;
    opq = $urandom_range(1, 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < flip_pct) opq = !opq;
      send_pixel(make_pixel(opq));
    end
  endtask

  initial begin : result_sink
    out_item_t got;
    string     msg;
    @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        out_tready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(5, 0) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        if (out_tvalid && out_tready) begin
          got.run_valid  = out_tuser;
          got.run_left   = out_tdata[RL_LO +: RUN_LEFT_W];
          got.run_right  = out_tdata[RR_LO +: RUN_RIGHT_W];
          got.run_row    = out_tdata[ROW_LO +: RUN_ROW_W];
          got.batch_end  = out_tlast;
          got.box_left   = out_tdata[BL_LO +: BOX_W];
          got.box_top    = out_tdata[BT_LO +: BOX_W];
          got.box_right  = out_tdata[BR_LO +: BOX_W];
          got.box_bottom = out_tdata[BB_LO +: BOX_W];
          msg = sb.check_result(got);
          if (msg != "") report_mismatch(msg);
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, key window edges, run left open for the width cut
    send_pixel(px(8'h00, 8'h00, 8'h00));
    send_pixel(px(8'h10, 8'h10, 8'h10));
    send_pixel(px(8'h11, 8'h00, 8'h00));
    send_pixel(px(8'h00, 8'h11, 8'h00));
    send_pixel(px(8'h00, 8'h00, 8'h11));
    send_pixel(px(8'hff, 8'hff, 8'hff));
    send_pixel(px(8'h00, 8'h00, 8'h00));
    send_pixel(px(8'hff, 8'h00, 8'h00));

    // narrower row while mid-row, saturating tolerance
    configure(px(8'h40, 8'h80, 8'hff), px(8'h10, 8'hff, 8'h00), dim_t'(4), dim_t'(3));
    send_pixel(px(8'h40, 8'h80, 8'hff));
    send_pixel(px(8'h50, 8'hff, 8'hff));
    send_pixel(px(8'h3f, 8'h80, 8'hff));
    send_pixel(px(8'h51, 8'h80, 8'hff));
    send_pixel(px(8'h40, 8'h7f, 8'hff));
    send_pixel(px(8'h40, 8'h80, 8'hfe));
    send_pixel(px(8'h45, 8'hc0, 8'hff));
    send_pixel(px(8'h00, 8'h00, 8'h00));
    send_pixel(px(8'hff, 8'hff, 8'hff));
    send_pixel(px(8'h40, 8'h80, 8'hff));
    send_pixel(px(8'hff, 8'h00, 8'h00));
    send_pixel(px(8'h50, 8'h80, 8'hff));

    // zero sizes clamp to a one-pixel frame: empty and single-run batches
    configure(cur_key, cur_tol, '0, '0);
    send_pixel(px(8'h40, 8'h80, 8'hff));
    send_pixel(px(8'h00, 8'h80, 8'hff));
    send_pixel(px(8'h50, 8'hff, 8'hff));
    send_pixel(px(8'hff, 8'hff, 8'h00));

    for (i = 0; i < 12; i++) begin
      random_setting();
      run_random($urandom_range(60, 45), $urandom_range(70, 5));
    end

    // every pixel closes a one-pixel frame while the receiver holds off
    align_frame();
    hold_req = HOLD_CYCLES;
    run_random(60, 50);

    quiet = 1'b1;
    for (i = 0; i < 2; i++) begin
      random_setting();
      run_random(40, $urandom_range(70, 5));
    end

    in_tvalid <= 1'b0;
    for (i = 0; i < 20000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      report_mismatch($sformatf("%0d expected result items never came", sb.pending()));
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
